@@ rtl/core/hsct_pkg.sv @@
// Shared constants and helpers for the half-segment cylinder transform.
// Used by hsct_sqrt and the top level; depends on nothing.
package hsct_pkg;

  localparam int COORD_W = 32;
  localparam int RAD_W = 31;
  localparam int ABS_W = 33;
  localparam int SUM_W = 66;
  localparam int ROOT_W = 35;
  localparam int SQ_REM_W = 70;
  localparam int WIDE_W = 72;

  localparam logic [1:0] ROW_CENTRE = 2'd3;
  localparam logic [2:0] LAST_BEAT = 3'd7;

  localparam logic signed [WIDE_W-1:0] SAT_MAX = WIDE_W'(64'sh7FFF_FFFF);
  localparam logic signed [WIDE_W-1:0] SAT_MIN = -WIDE_W'(64'sh8000_0000);

  // Clamps a wide signed value to the 32-bit signed range.
  function automatic logic signed [31:0] sat32(input logic signed [WIDE_W-1:0] x);
    logic signed [31:0] r;
    if (x > SAT_MAX) begin
      r = 32'sh7FFF_FFFF;
    end else if (x < SAT_MIN) begin
      r = 32'sh8000_0000;
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

endpackage

@@ rtl/core/hsct_sqrt.sv @@
// Pipelined integer square root, one result bit per register stage.
// Depends on hsct_pkg for the operand and root widths.
module hsct_sqrt #(
  parameter int SW = 1
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             en,
  input  logic                             in_valid,
  input  logic [hsct_pkg::SUM_W-1:0]       radicand,
  input  logic [SW-1:0]                    side,
  output logic                             out_valid,
  output logic [hsct_pkg::ROOT_W-1:0]      root,
  output logic [SW-1:0]                    side_out
);

  localparam int RTW = hsct_pkg::ROOT_W;
  localparam int REMW = hsct_pkg::SQ_REM_W;

  logic [RTW:0] vld;
  logic [RTW:0][REMW-1:0] rem;
  logic [RTW:0][RTW-1:0] rt;
  logic [RTW:0][SW-1:0] sd;

  assign vld[0] = in_valid;
  assign rem[0] = REMW'(radicand);
  assign rt[0] = '0;
  assign sd[0] = side;

  for (genvar k = 0; k < RTW; k++) begin : g_stage
    localparam int B = RTW - 1 - k;
    logic [REMW-1:0] trial;
    logic take;

    assign trial = (REMW'(rt[k]) << (B + 1)) + (REMW'(1) << (2 * B));
    assign take = rem[k] >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (en) begin
        vld[k+1] <= vld[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[k+1] <= take ? rem[k] - trial : rem[k];
        rt[k+1] <= take ? (rt[k] | (RTW'(1) << B)) : rt[k];
        sd[k+1] <= sd[k];
      end
    end
  end

  assign out_valid = vld[RTW];
  assign root = rt[RTW];
  assign side_out = sd[RTW];

endmodule

@@ rtl/core/hsct_div.sv @@
// Pipelined restoring divider over several lanes with a shared divisor.
// One quotient bit per register stage; depends on nothing else.
module hsct_div #(
  parameter int NW = 8,
  parameter int DW = 8,
  parameter int QW = 8,
  parameter int LANES = 1,
  parameter int SW = 1
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        en,
  input  logic                        in_valid,
  input  logic [LANES-1:0][NW-1:0]    dividend,
  input  logic [DW-1:0]               divisor,
  input  logic [SW-1:0]               side,
  output logic                        out_valid,
  output logic [LANES-1:0][QW-1:0]    quot,
  output logic [SW-1:0]               side_out
);

  localparam int RW = (NW > DW + QW) ? NW : DW + QW;

  logic [QW:0] vld;
  logic [QW:0][LANES-1:0][RW-1:0] rem;
  logic [QW:0][LANES-1:0][QW-1:0] q;
  logic [QW:0][DW-1:0] dv;
  logic [QW:0][SW-1:0] sd;

  assign vld[0] = in_valid;
  assign dv[0] = divisor;
  assign sd[0] = side;

  for (genvar l = 0; l < LANES; l++) begin : g_init
    assign rem[0][l] = RW'(dividend[l]);
    assign q[0][l] = '0;
  end

  for (genvar k = 0; k < QW; k++) begin : g_stage
    localparam int J = QW - 1 - k;
    logic [RW-1:0] trial;

    assign trial = RW'(dv[k]) << J;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (en) begin
        vld[k+1] <= vld[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dv[k+1] <= dv[k];
        sd[k+1] <= sd[k];
      end
    end

    for (genvar l = 0; l < LANES; l++) begin : g_lane
      logic take;

      assign take = rem[k][l] >= trial;

      always_ff @(posedge clk) begin
        if (en) begin
          rem[k+1][l] <= take ? rem[k][l] - trial : rem[k][l];
          q[k+1][l] <= {q[k][l][QW-2:0], take};
        end
      end
    end
  end

  assign out_valid = vld[QW];
  assign quot = q[QW];
  assign side_out = sd[QW];

endmodule

@@ rtl/core/half_segment_cylinder_transform.sv @@
// Top level of the half-segment cylinder transform: length, direction and
// two placement matrices per request. Uses hsct_pkg, hsct_sqrt and hsct_div.
//
//   channel | dir | tdata                                  | tuser / tlast
//   s_*     | in  | start xyz, end xyz, radius (224 bits)   | none
//   m_*     | out | entry_0..entry_3 (128 bits)            | half, row / last
//
// Data passes the front stages, the square root, the direction divider, the rotation
// stages, the rotation divider, the scale stages and the output buffer; the root and
// dividers take one bit per stage. A request leaves as eight beats while later ones enter.
// The whole pipeline advances together and holds while the output buffer is full.
// Reset clears only the valid bits and the output beat counter.
module half_segment_cylinder_transform #(
  parameter int FRAC_BITS = 16
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [223:0] s_tdata,   // start_x, start_y, start_z, end_x, end_y, end_z, radius
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [127:0] m_tdata,   // entry_0, entry_1, entry_2, entry_3
  output logic [2:0]   m_tuser,   // half_select, row_index
  output logic         m_tlast
);

  localparam int F = FRAC_BITS;
  localparam int CW = hsct_pkg::COORD_W;
  localparam int RDW = hsct_pkg::RAD_W;
  localparam int AW = hsct_pkg::ABS_W;
  localparam int HW = hsct_pkg::ROOT_W;
  localparam int WW = hsct_pkg::WIDE_W;
  localparam int VW = F + 2;
  localparam int MW = F + 1;
  localparam int PW = F + 2;
  localparam int N1 = AW + F;
  localparam int Q1 = F + 1;
  localparam int N2 = 2 * F + 2;
  localparam int Q2 = 2 * F + 1;
  localparam int SQ_SW = 6 * CW + RDW + 3 * AW + 3;
  localparam int D1_SW = 6 * CW + RDW + 3 + HW + 1;
  localparam int D2_SW = 3 * VW + HW + 6 * CW + RDW + 2;

  localparam logic signed [VW-1:0] ONE_V = VW'(1) << F;
  localparam logic signed [VW:0] ONE_X = (VW + 1)'(1) << F;
  localparam logic signed [WW-1:0] RND = (WW'(1) << F) - WW'(1);
  localparam logic [31:0] ONE_32 = 32'(1) << F;

  function automatic logic signed [31:0] qfin(input logic signed [WW-1:0] x);
    logic signed [WW-1:0] t;
    t = x;
    if (x[WW-1]) begin
      t = x + RND;
    end
    return hsct_pkg::sat32(t >>> F);
  endfunction

  logic en;
  logic load;
  logic busy;
  logic [2:0] cnt;

  // Front stages: capture, difference, squares, sum.
  logic v1, v2, v3, v4;
  logic [2:0][31:0] s1, e1, s2, e2, s3, e3, s4, e4;
  logic [RDW-1:0] r1, r2, r3, r4;
  logic [2:0][AW-1:0] ad2, ad3, ad4;
  logic [2:0] dn2, dn3, dn4;
  logic [2:0][2*AW-1:0] sq3;
  logic [hsct_pkg::SUM_W-1:0] sum4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else if (en) begin
      v1 <= s_tvalid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        s1[i] <= s_tdata[i*CW +: CW];
        e1[i] <= s_tdata[(i+3)*CW +: CW];
      end
      r1 <= s_tdata[6*CW +: RDW];
      for (int i = 0; i < 3; i++) begin
        logic signed [AW-1:0] d;
        d = AW'($signed(e1[i])) - AW'($signed(s1[i]));
        dn2[i] <= d[AW-1];
        ad2[i] <= d[AW-1] ? AW'(-d) : AW'(d);
      end
      s2 <= s1;
      e2 <= e1;
      r2 <= r1;
      for (int i = 0; i < 3; i++) begin
        sq3[i] <= (2*AW)'(ad2[i]) * (2*AW)'(ad2[i]);
      end
      s3 <= s2;
      e3 <= e2;
      r3 <= r2;
      ad3 <= ad2;
      dn3 <= dn2;
      sum4 <= hsct_pkg::SUM_W'(sq3[0]) + hsct_pkg::SUM_W'(sq3[1])
            + hsct_pkg::SUM_W'(sq3[2]);
      s4 <= s3;
      e4 <= e3;
      r4 <= r3;
      ad4 <= ad3;
      dn4 <= dn3;
    end
  end

  // Length.
  logic sq_v;
  logic [HW-1:0] h_sq;
  logic [SQ_SW-1:0] sq_side;
  logic [2:0][31:0] s_sq, e_sq;
  logic [RDW-1:0] r_sq;
  logic [2:0][AW-1:0] ad_sq;
  logic [2:0] dn_sq;

  hsct_sqrt #(.SW(SQ_SW)) u_sqrt (
    .clk(clk), .rst(rst), .en(en), .in_valid(v4), .radicand(sum4),
    .side({dn4, ad4, r4, e4, s4}),
    .out_valid(sq_v), .root(h_sq), .side_out(sq_side)
  );

  assign {dn_sq, ad_sq, r_sq, e_sq, s_sq} = sq_side;

  // Unit direction.
  logic [2:0][N1-1:0] n1;
  logic d1_v;
  logic [2:0][Q1-1:0] q1;
  logic [D1_SW-1:0] d1_side;
  logic [2:0][31:0] s_d1, e_d1;
  logic [RDW-1:0] r_d1;
  logic [2:0] dn_d1;
  logic [HW-1:0] h_d1;
  logic hz_d1;

  for (genvar i = 0; i < 3; i++) begin : g_n1
    assign n1[i] = N1'(ad_sq[i]) << F;
  end

  hsct_div #(.NW(N1), .DW(HW), .QW(Q1), .LANES(3), .SW(D1_SW)) u_div_dir (
    .clk(clk), .rst(rst), .en(en), .in_valid(sq_v), .dividend(n1), .divisor(h_sq),
    .side({h_sq == '0, h_sq, dn_sq, r_sq, e_sq, s_sq}),
    .out_valid(d1_v), .quot(q1), .side_out(d1_side)
  );

  assign {hz_d1, h_d1, dn_d1, r_d1, e_d1, s_d1} = d1_side;

  // Rotation terms and the quotient products.
  logic v5, v6;
  logic signed [VW-1:0] wx5, wy5, c5, wx6, wy6, c6;
  logic [PW-1:0] p5;
  logic [HW-1:0] h5, h6;
  logic [2:0][31:0] s5, e5, s6, e6;
  logic [RDW-1:0] r5, r6;
  logic [2:0][N2-1:0] m6;
  logic [PW-1:0] p6;
  logic sxy6, pz6;

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
      v6 <= 1'b0;
    end else if (en) begin
      v5 <= d1_v;
      v6 <= v5;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      logic signed [VW-1:0] vv [3];
      logic signed [VW:0] psum;
      logic [MW-1:0] ax, ay;
      for (int i = 0; i < 3; i++) begin
        vv[i] = $signed({1'b0, q1[i]});
        if (dn_d1[i]) begin
          vv[i] = -vv[i];
        end
      end
      if (hz_d1) begin
        vv[0] = '0;
        vv[1] = '0;
        vv[2] = ONE_V;
      end
      psum = {vv[2][VW-1], vv[2]} + ONE_X;
      wx5 <= -vv[1];
      wy5 <= vv[0];
      c5 <= vv[2];
      p5 <= psum[PW-1:0];
      h5 <= h_d1;
      s5 <= s_d1;
      e5 <= e_d1;
      r5 <= r_d1;

      ax = wx5[VW-1] ? MW'(-wx5) : MW'(wx5);
      ay = wy5[VW-1] ? MW'(-wy5) : MW'(wy5);
      m6[0] <= N2'(ax) * N2'(ax);
      m6[1] <= N2'(ax) * N2'(ay);
      m6[2] <= N2'(ay) * N2'(ay);
      sxy6 <= wx5[VW-1] ^ wy5[VW-1];
      pz6 <= p5 == '0;
      p6 <= p5;
      wx6 <= wx5;
      wy6 <= wy5;
      c6 <= c5;
      h6 <= h5;
      s6 <= s5;
      e6 <= e5;
      r6 <= r5;
    end
  end

  logic d2_v;
  logic [2:0][Q2-1:0] q2;
  logic [D2_SW-1:0] d2_side;
  logic signed [VW-1:0] wx_d2, wy_d2, c_d2;
  logic [HW-1:0] h_d2;
  logic [2:0][31:0] s_d2, e_d2;
  logic [RDW-1:0] r_d2;
  logic sxy_d2, pz_d2;

  hsct_div #(.NW(N2), .DW(PW), .QW(Q2), .LANES(3), .SW(D2_SW)) u_div_rot (
    .clk(clk), .rst(rst), .en(en), .in_valid(v6), .dividend(m6), .divisor(p6),
    .side({pz6, sxy6, r6, e6, s6, h6, c6, wy6, wx6}),
    .out_valid(d2_v), .quot(q2), .side_out(d2_side)
  );

  assign {pz_d2, sxy_d2, r_d2, e_d2, s_d2, h_d2, c_d2, wy_d2, wx_d2} = d2_side;

  // Scale operands, products, rounding and clamping.
  logic v7, v8, mat_v;
  logic [4:0][31:0] rm7;
  logic [2:0][31:0] hm7;
  logic [2:0][31:0] ca7, cb7, ca8, cb8, ca9, cb9;
  logic [RDW-1:0] r7;
  logic [HW-1:0] h7;
  logic [4:0][63:0] pr8;
  logic [2:0][HW+32:0] ph8;
  logic [4:0][31:0] qr9;
  logic [2:0][31:0] qh9;

  always_ff @(posedge clk) begin
    if (rst) begin
      v7 <= 1'b0;
      v8 <= 1'b0;
      mat_v <= 1'b0;
    end else if (en) begin
      v7 <= d2_v;
      v8 <= v7;
      mat_v <= v8;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      logic signed [WW-1:0] t [3];
      logic signed [31:0] qs [3];
      logic signed [CW+2:0] cs;
      for (int i = 0; i < 3; i++) begin
        t[i] = WW'($signed({1'b0, q2[i]}));
      end
      if (sxy_d2) begin
        t[1] = -t[1];
      end
      for (int i = 0; i < 3; i++) begin
        qs[i] = pz_d2 ? 32'sd0 : hsct_pkg::sat32(t[i]);
      end
      rm7[0] <= hsct_pkg::sat32(WW'(qs[0]) + WW'(c_d2));
      rm7[1] <= qs[1];
      rm7[2] <= 32'(-wy_d2);
      rm7[3] <= hsct_pkg::sat32(WW'(qs[2]) + WW'(c_d2));
      rm7[4] <= 32'(wx_d2);
      hm7[0] <= 32'(wy_d2);
      hm7[1] <= 32'(-wx_d2);
      hm7[2] <= 32'(c_d2);
      for (int i = 0; i < 3; i++) begin
        cs = ((CW+3)'($signed(s_d2[i])) <<< 1) + (CW+3)'($signed(s_d2[i]))
           + (CW+3)'($signed(e_d2[i]));
        ca7[i] <= 32'(cs >>> 2);
        cs = ((CW+3)'($signed(e_d2[i])) <<< 1) + (CW+3)'($signed(e_d2[i]))
           + (CW+3)'($signed(s_d2[i]));
        cb7[i] <= 32'(cs >>> 2);
      end
      r7 <= r_d2;
      h7 <= h_d2;

      for (int i = 0; i < 5; i++) begin
        pr8[i] <= $signed({1'b0, r7}) * $signed(rm7[i]);
      end
      for (int i = 0; i < 3; i++) begin
        ph8[i] <= $signed({1'b0, h7}) * $signed(hm7[i]);
      end
      ca8 <= ca7;
      cb8 <= cb7;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 5; i++) begin
        qr9[i] <= qfin(WW'($signed(pr8[i])));
      end
      for (int i = 0; i < 3; i++) begin
        qh9[i] <= qfin(WW'($signed(ph8[i])));
      end
      ca9 <= ca8;
      cb9 <= cb8;
    end
  end

  // Output buffer: one request as eight beats.
  logic [2:0][2:0][31:0] rows;
  logic [2:0][31:0] cen_a, cen_b;

  assign load = mat_v && (!busy || (m_tready && cnt == hsct_pkg::LAST_BEAT));
  assign en = !mat_v || load;
  assign s_tready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt <= '0;
    end else if (load) begin
      busy <= 1'b1;
      cnt <= '0;
    end else if (busy && m_tready) begin
      cnt <= cnt + 3'd1;
      if (cnt == hsct_pkg::LAST_BEAT) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      rows[0] <= {qr9[2], qr9[1], qr9[0]};
      rows[1] <= {qr9[4], qr9[3], qr9[1]};
      rows[2] <= qh9;
      cen_a <= ca9;
      cen_b <= cb9;
    end
  end

  always_comb begin
    case (cnt[1:0])
      2'd0: m_tdata = {32'd0, rows[0][2], rows[0][1], rows[0][0]};
      2'd1: m_tdata = {32'd0, rows[1][2], rows[1][1], rows[1][0]};
      2'd2: m_tdata = {32'd0, rows[2][2], rows[2][1], rows[2][0]};
      hsct_pkg::ROW_CENTRE: begin
        if (cnt[2]) begin
          m_tdata = {ONE_32, cen_b[2], cen_b[1], cen_b[0]};
        end else begin
          m_tdata = {ONE_32, cen_a[2], cen_a[1], cen_a[0]};
        end
      end
      default: m_tdata = '0;
    endcase
  end

  assign m_tvalid = busy;
  assign m_tuser = {cnt[1:0], cnt[2]};
  assign m_tlast = cnt == hsct_pkg::LAST_BEAT;

endmodule

@@ rtl/core/hsct_check.sv @@
// Port-level checks for half_segment_cylinder_transform, bound to the top level.
// Depends only on the top level's ports.
module hsct_check #(
  parameter int FRAC_BITS = 16
) (
  input logic         clk,
  input logic         rst,
  input logic         s_tvalid,
  input logic         s_tready,
  input logic [223:0] s_tdata,
  input logic         m_tvalid,
  input logic         m_tready,
  input logic [127:0] m_tdata,
  input logic [2:0]   m_tuser,
  input logic         m_tlast
);

  localparam logic [31:0] ONE_32 = 32'(1) << FRAC_BITS;

  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && !s_tready |=> s_tvalid && $stable(s_tdata))
    else $error("Request changed while waiting.");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("Result changed while stalled.");

  a_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tlast == (m_tuser == 3'b111)))
    else $error("Last flag does not match the final beat.");

  a_burst: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && !m_tlast |=> m_tvalid && (m_tuser == $past(m_tuser) + 3'd2
      || m_tuser == $past(m_tuser) - 3'd5))
    else $error("Beats of a request are not contiguous and in order.");

  a_fourth: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tuser[2:1] == 2'd3 ? m_tdata[127:96] == ONE_32 : m_tdata[127:96] == 32'd0))
    else $error("Fourth entry is wrong for its row.");

endmodule

bind half_segment_cylinder_transform hsct_check #(.FRAC_BITS(FRAC_BITS)) u_hsct_check (.*);
